/* design/asr_pkg.sv */
// Shared types, constants and GF(2^8) helpers for the AES SubBytes row pipeline.
package asr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned StageCnt = 3;
  localparam logic [ByteW-1:0] PolyLow     = 8'h1B;
  localparam logic [ByteW-1:0] AffineConst = 8'h63;

  typedef logic [ByteW-1:0] byte_t;

  // per-stage load enables, stage 0 nearest the input
  typedef struct packed {
    logic [StageCnt-1:0] en;
  } asr_ctrl_t;

  // product modulo x^8+x^4+x^3+x+1
  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < ByteW; i++) begin
      if (b[i]) acc = acc ^ sh;
      sh = sh[ByteW-1] ? ({sh[ByteW-2:0], 1'b0} ^ PolyLow) : {sh[ByteW-2:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic byte_t gf_sq(input byte_t a);
    return gf_mul(a, a);
  endfunction

  function automatic byte_t rotl(input byte_t v, input int unsigned n);
    return byte_t'((v << n) | (v >> (ByteW - n)));
  endfunction

  function automatic byte_t affine(input byte_t b);
    return b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ AffineConst;
  endfunction

endpackage

/* design/asr_if.sv */
// Row channel interfaces: four input bytes and four substituted bytes.
interface asr_in_if;
  logic           valid;
  logic           ready;
  asr_pkg::byte_t byte_0;
  asr_pkg::byte_t byte_1;
  asr_pkg::byte_t byte_2;
  asr_pkg::byte_t byte_3;

  modport source (output valid, byte_0, byte_1, byte_2, byte_3, input ready);
  modport sink   (input valid, byte_0, byte_1, byte_2, byte_3, output ready);
endinterface

interface asr_out_if;
  logic           valid;
  logic           ready;
  asr_pkg::byte_t sub_0;
  asr_pkg::byte_t sub_1;
  asr_pkg::byte_t sub_2;
  asr_pkg::byte_t sub_3;

  modport source (output valid, sub_0, sub_1, sub_2, sub_3, input ready);
  modport sink   (input valid, sub_0, sub_1, sub_2, sub_3, output ready);
endinterface

/* design/asr_ctrl.sv */
// Valid bits and stall control for the three-stage pipeline.
module asr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output asr_pkg::asr_ctrl_t ctrl_o
);

  logic [asr_pkg::StageCnt-1:0] valid_d, valid_q;
  logic [asr_pkg::StageCnt-1:0] en;

  // a stage loads when empty or when its contents move on this cycle
  always_comb begin
    en[asr_pkg::StageCnt-1] = !valid_q[asr_pkg::StageCnt-1] || out_ready_i;
    for (int k = asr_pkg::StageCnt - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d    = valid_q;
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < asr_pkg::StageCnt; k++) begin
      if (en[k]) valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[asr_pkg::StageCnt-1];
  assign ctrl_o.en   = en;

endmodule

/* design/asr_lane.sv */
// One byte lane: GF(2^8) inverse by an addition chain to x^254, then the affine map.
module asr_lane (
  input  logic               clk_i,
  input  asr_pkg::asr_ctrl_t ctrl_i,
  input  asr_pkg::byte_t     byte_i,
  output asr_pkg::byte_t     sub_o
);

  asr_pkg::byte_t x2_d, x2_q, x3_d, x3_q;
  asr_pkg::byte_t x14_d, x14_q, x15_d, x15_q;
  asr_pkg::byte_t sub_d, sub_q;
  asr_pkg::byte_t x12, x240;

  // stage 0: x^2, x^3
  assign x2_d = asr_pkg::gf_sq(byte_i);
  assign x3_d = asr_pkg::gf_mul(x2_d, byte_i);

  // stage 1: x^12 = (x^3)^4, then x^14 and x^15
  assign x12   = asr_pkg::gf_sq(asr_pkg::gf_sq(x3_q));
  assign x14_d = asr_pkg::gf_mul(x12, x2_q);
  assign x15_d = asr_pkg::gf_mul(x12, x3_q);

  // stage 2: x^254 = x^240 * x^14; zero stays zero
  assign x240  = asr_pkg::gf_sq(asr_pkg::gf_sq(asr_pkg::gf_sq(asr_pkg::gf_sq(x15_q))));
  assign sub_d = asr_pkg::affine(asr_pkg::gf_mul(x240, x14_q));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      x2_q <= x2_d;
      x3_q <= x3_d;
    end
    if (ctrl_i.en[1]) begin
      x14_q <= x14_d;
      x15_q <= x15_d;
    end
    if (ctrl_i.en[2]) begin
      sub_q <= sub_d;
    end
  end

  assign sub_o = sub_q;

endmodule

/* design/aes_subbytes_row.sv */
// Top level: forward AES SubBytes on a row of four bytes, three-stage pipeline.
//
//   channel  dir  handshake          payload
//   in_i     in   valid / ready      byte_0 .. byte_3, 8 bits each
//   out_o    out  valid / ready      sub_0 .. sub_3, 8 bits each
//
// Each input beat passes through the three registered stages (x^2/x^3, x^14/x^15,
// sub) before it reaches out_o. One beat per cycle is sustained while out_o.ready
// stays high, each stage holding a chain of GF(2^8) multiplies per lane.
// Reset clears the stage valid bits only; datapath registers are not reset.
// A stall at the output holds the last stage and backs up stage by stage;
// empty stages still fill, so in_i.ready stays high until the pipe is full.
module aes_subbytes_row (
  input  logic clk_i,
  input  logic rst_ni,
  asr_in_if.sink    in_i,
  asr_out_if.source out_o
);

  asr_pkg::asr_ctrl_t ctrl;
  asr_pkg::byte_t     byte_in  [4];
  asr_pkg::byte_t     sub_out  [4];

  asr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  assign byte_in[0] = in_i.byte_0;
  assign byte_in[1] = in_i.byte_1;
  assign byte_in[2] = in_i.byte_2;
  assign byte_in[3] = in_i.byte_3;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    asr_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .byte_i (byte_in[g]),
      .sub_o  (sub_out[g])
    );
  end

  assign out_o.sub_0 = sub_out[0];
  assign out_o.sub_1 = sub_out[1];
  assign out_o.sub_2 = sub_out[2];
  assign out_o.sub_3 = sub_out[3];

endmodule

/* bench/testbench.sv */
// Self-checking bench for aes_subbytes_row: row beats in, S-box rows checked out.
`timescale 1ns / 1ps

module testbench;
  typedef asr_pkg::byte_t byte_t;

  localparam int unsigned PipeDepth = 3;
  localparam int unsigned WatchLimit = 1000;

  typedef struct packed {
    byte_t s0;
    byte_t s1;
    byte_t s2;
    byte_t s3;
  } subs_t;

  logic clk_i;
  logic rst_ni;

  asr_in_if  row_in ();
  asr_out_if row_out ();

  aes_subbytes_row dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (row_in),
    .out_o  (row_out)
  );

  subs_t       pending_subs[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          src_jitter;
  bit          snk_jitter;
  int unsigned snk_hold;
  int unsigned snk_hold_req;

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    row_in.valid    = 1'b0;
    row_in.byte_0   = '0;
    row_in.byte_1   = '0;
    row_in.byte_2   = '0;
    row_in.byte_3   = '0;
    row_out.ready   = 1'b0;
    mismatches      = 0;
    quiet_cycles    = 0;
    src_jitter      = 1'b0;
    snk_jitter      = 1'b0;
    snk_hold        = 0;
    snk_hold_req    = 0;
  end

  always #10 clk_i = ~clk_i;

  // --- S-box prediction ---------------------------------------------------

  function automatic byte_t gf_times(input byte_t x, input byte_t y);
    byte_t prod;
    byte_t run;
    prod = '0;
    run  = x;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) prod ^= run;
      run = {run[6:0], 1'b0} ^ (run[7] ? asr_pkg::PolyLow : 8'h00);
    end
    return prod;
  endfunction

  // x^254 is the inverse, and maps zero onto zero
  function automatic byte_t subst_byte(input byte_t x);
    byte_t inv;
    byte_t pw;
    byte_t s;
    inv = 8'h01;
    pw  = x;
    for (int k = 0; k < 8; k++) begin
      if (k != 0) inv = gf_times(inv, pw);
      pw = gf_times(pw, pw);
    end
    for (int i = 0; i < 8; i++)
      s[i] = inv[i] ^ inv[(i + 4) % 8] ^ inv[(i + 5) % 8] ^ inv[(i + 6) % 8]
             ^ inv[(i + 7) % 8] ^ asr_pkg::AffineConst[i];
    return s;
  endfunction

  function automatic subs_t sbox_row(input byte_t b0, input byte_t b1,
                                     input byte_t b2, input byte_t b3);
    subs_t r;
    r.s0 = subst_byte(b0);
    r.s1 = subst_byte(b1);
    r.s2 = subst_byte(b2);
    r.s3 = subst_byte(b3);
    return r;
  endfunction

  // --- idle lengths: mostly none or short, now and then long ---------------

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic byte_t pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // --- driving -------------------------------------------------------------

  task automatic send_row(input byte_t b0, input byte_t b1,
                          input byte_t b2, input byte_t b3);
    int unsigned gap;
    gap = src_jitter ? idle_len() : 0;
    if (gap != 0) begin
      row_in.valid  <= 1'b0;
      row_in.byte_0 <= byte_t'($urandom_range(0, 255));
      repeat (gap) @(posedge clk_i);
    end
    row_in.valid  <= 1'b1;
    row_in.byte_0 <= b0;
    row_in.byte_1 <= b1;
    row_in.byte_2 <= b2;
    row_in.byte_3 <= b3;
    @(posedge clk_i);
    while (!row_in.ready) @(posedge clk_i);
  endtask

  task automatic send_random_row();
    send_row(pick_byte(), pick_byte(), pick_byte(), pick_byte());
  endtask

  task automatic quiet_source();
    row_in.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    quiet_source();
    while (pending_subs.size() != 0) @(posedge clk_i);
  endtask

  // sink ready: random holds, or one long hold on request
  always @(posedge clk_i) begin
    if (snk_hold_req != 0) begin
      snk_hold     = snk_hold_req;
      snk_hold_req = 0;
    end
    if (snk_hold == 0 && snk_jitter && $urandom_range(0, 3) == 0)
      snk_hold = idle_len();
    if (snk_hold != 0) begin
      row_out.ready <= 1'b0;
      snk_hold--;
    end else begin
      row_out.ready <= 1'b1;
    end
  end

  // --- checking ------------------------------------------------------------

  task automatic check_lane(input string name, input byte_t want, input byte_t got);
    if (want !== got) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    subs_t want;
    if (rst_ni) begin
      if (row_in.valid && row_in.ready)
        pending_subs.push_back(sbox_row(row_in.byte_0, row_in.byte_1,
                                        row_in.byte_2, row_in.byte_3));
      if (row_out.valid && row_out.ready) begin
        if (pending_subs.size() == 0) begin
          $error("output beat with nothing expected: %02h %02h %02h %02h",
                 row_out.sub_0, row_out.sub_1, row_out.sub_2, row_out.sub_3);
          mismatches++;
        end else begin
          want = pending_subs.pop_front();
          check_lane("sub_0", want.s0, row_out.sub_0);
          check_lane("sub_1", want.s1, row_out.sub_1);
          check_lane("sub_2", want.s2, row_out.sub_2);
          check_lane("sub_3", want.s3, row_out.sub_3);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (row_in.valid && row_in.ready) || (row_out.valid && row_out.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("aes_subbytes_row regression: fail");
      $finish;
    end
  end

  // --- tests ---------------------------------------------------------------

  // zero, one, top bit, all ones, and a walking one or zero in each lane
  task automatic test_corner_bytes();
    byte_t w;
    src_jitter = 1'b0;
    snk_jitter = 1'b0;
    send_row(8'h00, 8'h01, 8'hFF, 8'h80);
    send_row(8'h01, 8'h00, 8'h80, 8'hFF);
    send_row(8'hFF, 8'h80, 8'h00, 8'h01);
    send_row(8'h80, 8'hFF, 8'h01, 8'h00);
    send_row(8'h00, 8'h00, 8'h00, 8'h00);
    send_row(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_row(8'h01, 8'h01, 8'h01, 8'h01);
    send_row(8'h7F, 8'hFE, 8'h53, 8'hCA);
    for (int b = 0; b < 8; b++) begin
      w = byte_t'(1) << b;
      send_row(w, ~w, {w[6:0], w[7]}, ~{w[0], w[7:1]});
    end
    wait_drained();
  endtask

  // every byte value passes through every lane
  task automatic test_full_table();
    src_jitter = 1'b1;
    snk_jitter = 1'b1;
    for (int i = 0; i < 256; i++)
      send_row(byte_t'(i), byte_t'(i + 64), byte_t'(i + 128), byte_t'(i + 192));
    wait_drained();
  endtask

  // sink holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    src_jitter   = 1'b0;
    snk_jitter   = 1'b0;
    snk_hold_req = 60;
    repeat (24) send_random_row();
    wait_drained();
  endtask

  // bursts, each one drained completely before the next
  task automatic test_drain_pause();
    src_jitter = 1'b0;
    snk_jitter = 1'b1;
    for (int k = 0; k < 8; k++) begin
      repeat ($urandom_range(1, 12)) send_random_row();
      wait_drained();
    end
  endtask

  task automatic test_random_rows();
    for (int seg = 0; seg < 12; seg++) begin
      src_jitter = seg[0];
      snk_jitter = seg[1];
      repeat (70) send_random_row();
      if (seg % 4 == 3) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_bytes();
    test_full_table();
    test_backpressure();
    test_drain_pause();
    test_random_rows();
    repeat (PipeDepth + 8) @(posedge clk_i);
    if (pending_subs.size() != 0) begin
      $error("%0d expected rows never came out", pending_subs.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("aes_subbytes_row regression: pass");
    else
      $display("aes_subbytes_row regression: fail");
    $finish;
  end

endmodule
